// ===== sv/unshrink_lzw_decoder_defines.svh =====
// Assertion macros shared by the unshrink LZW decoder RTL.
// Depends on nothing; the using module must provide clk and rst_n.
`ifndef UNSHRINK_LZW_DECODER_DEFINES_SVH
`define UNSHRINK_LZW_DECODER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ULZW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ULZW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ULZW_ASSERT(lbl, prop, msg)
`define ULZW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/ulzw_pkg.sv =====
// Shared types and constants of the unshrink LZW decoder.
// Used by every module of the block; depends on nothing.
package ulzw_pkg;

    localparam int START_CODE_BITS = 9;
    localparam int FIRST_FREE      = 257;
    localparam int CODE_CLEAR      = 256;
    localparam int SUB_WIDEN       = 1;
    localparam int SUB_PCLEAR      = 2;
    localparam int BUF_W           = 32;
    localparam int HELD_W          = 6;
    localparam int FULL_HELD       = 24;
    localparam int CWID_W          = 4;

    localparam logic [15:0] FREE_MARK = 16'hFFFF;
    localparam logic [15:0] MARK_BIT  = 16'h8000;
    localparam logic [15:0] KEEP_MASK = 16'h7FFF;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    typedef enum logic [2:0] {
        STAT_BYTE     = 3'd0,
        STAT_ACCEPTED = 3'd1,
        STAT_NEED     = 3'd2,
        STAT_REFUSED  = 3'd3,
        STAT_DONE     = 3'd4,
        STAT_CORRUPT  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_NORMAL = 2'd1,
        PH_SUB    = 2'd2
    } phase_t;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_CODE, S_WRD, S_WEV, S_FRD, S_FEV,
        S_P1RD, S_P1WR, S_P2RD, S_P2EV, S_P2WR, S_P3RD, S_P3WR,
        S_PRD, S_POP, S_OUT
    } state_t;

    typedef struct packed {
        logic push;
        logic take;
    } bb_ctl_t;

    typedef struct packed {
        logic pwe;
        logic swe;
    } dict_ctl_t;

endpackage

// ===== sv/unshrink_lzw_decoder.sv =====
// Top level of the unshrink (dynamic LZW with partial clearing) decoder.
// Depends on ulzw_pkg, ulzw_bitbuf, ulzw_dict and unshrink_lzw_decoder_defines.svh.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tuser=cmd, tdata=in_byte, tlast
//  m_*      | out       | m_tvalid/m_tready  | tdata=out_byte, tuser=status
//  cfg_*    | in        | cfg_we             | cfg_wdata=out_limit
//
// After reset the dictionary is swept once, one entry per cycle, so the block
// accepts no item until the sweep ends; configuration writes are taken at once.
// A push goes from idle straight to the output state; a pull that finds stacked
// bytes reads and pops the stack first. A pull that decodes a code reads and then
// evaluates an entry for each dictionary step and each probe of the next-free
// search, all on the single dictionary read port.
// The block takes one item at a time. A finished result moves into the output
// register and the block is ready again; if that register still holds a result
// that has not been taken, the block waits with s_tready low until it is taken.
`include "unshrink_lzw_decoder_defines.svh"
module unshrink_lzw_decoder #(
    parameter int DICT_ENTRIES  = 8192,
    parameter int MAX_CODE_BITS = 13
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] cmd
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [2:0]  m_tuser,   // [2:0] status
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);
    import ulzw_pkg::*;

    localparam int AW   = $clog2(DICT_ENTRIES);
    localparam int SP_W = AW + 1;
    localparam int CW   = MAX_CODE_BITS;

    localparam logic [SP_W-1:0] DICT_N  = SP_W'(DICT_ENTRIES);
    localparam logic [SP_W-1:0] FREE_1ST = SP_W'(FIRST_FREE);

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [SP_W-1:0]   nf_reg, nf_next;
    logic [SP_W-1:0]   idx_reg, idx_next;
    logic [CWID_W-1:0] cw_reg, cw_next;
    logic [CW-1:0]     prev_reg, prev_next;
    logic [CW-1:0]     code_reg, code_next;
    logic [15:0]       c_reg, c_next;
    logic [7:0]        final_reg, final_next;
    logic              first_reg, first_next;
    logic              fromclr_reg, fromclr_next;
    logic              end_reg, end_next;
    logic              corrupt_reg, corrupt_next;
    logic              done_reg, done_next;
    logic [31:0]       bytes_reg, bytes_next;
    logic [31:0]       limit_reg;
    logic [7:0]        res_byte_reg, res_byte_next;
    status_t           res_stat_reg, res_stat_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_data_reg, m_data_next;
    status_t           m_user_reg, m_user_next;

    // Shared units.
    bb_ctl_t           bb_ctl;
    logic [CW-1:0]     bb_code;
    logic [HELD_W-1:0] bb_held;
    dict_ctl_t         d_ctl;
    logic [AW-1:0]     d_waddr, d_raddr;
    logic [15:0]       d_wprefix, d_rprefix;
    logic [7:0]        d_wsuffix, d_rsuffix;

    // Reversal stack, local to this module.
    logic [7:0]        stack_mem [DICT_ENTRIES];
    logic              stk_we;
    logic [AW-1:0]     stk_waddr, stk_raddr;
    logic [7:0]        stk_wdata, stk_q;

    // Decision terms shared by the next-state and datapath logic.
    logic accept, is_pull, short_bits, out_free, stk_full, nf_full, idx_end;
    logic c_over, c_inner, walk_free, self_ref, p2_hit;
    logic [15:0] p2_target;

    ulzw_bitbuf #(.CW(CW)) u_bitbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (bb_ctl),
        .push_byte (s_tdata),
        .width     (cw_reg),
        .code      (bb_code),
        .held      (bb_held)
    );

    ulzw_dict #(.DICT_ENTRIES(DICT_ENTRIES), .AW(AW)) u_dict (
        .clk     (clk),
        .ctl     (d_ctl),
        .waddr   (d_waddr),
        .wprefix (d_wprefix),
        .wsuffix (d_wsuffix),
        .raddr   (d_raddr),
        .rprefix (d_rprefix),
        .rsuffix (d_rsuffix)
    );

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        stk_q <= stack_mem[stk_raddr];
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign is_pull    = (s_tuser == CMD_PULL);
    assign short_bits = (bb_held < HELD_W'(cw_reg));
    assign out_free   = !m_valid_reg || m_tready;
    assign stk_full   = (sp_reg == '0);
    assign nf_full    = (nf_reg >= DICT_N);
    assign idx_end    = (idx_reg >= nf_reg);
    assign c_over     = (32'(c_reg) >= 32'(DICT_ENTRIES));
    assign c_inner    = (c_reg >= 16'(FIRST_FREE));
    // A free entry is the KwKwK case: it expands through the previous code.
    assign walk_free  = (first_reg || c_inner) && (d_rprefix == FREE_MARK);
    assign self_ref   = (d_rprefix == c_reg);
    assign p2_target  = d_rprefix & KEEP_MASK;
    assign p2_hit     = (p2_target >= 16'(FIRST_FREE)) &&
                        (32'(p2_target) < 32'(DICT_ENTRIES));

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (idx_reg == DICT_N - SP_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!is_pull || corrupt_reg || done_reg || bytes_reg >= limit_reg)
                    begin
                        state_next = S_OUT;
                    end
                    else if (sp_reg != DICT_N)
                    begin
                        state_next = S_PRD;
                    end
                    else
                    begin
                        state_next = S_CODE;
                    end
                end
            end
            S_CODE:
            begin
                if (short_bits)
                begin
                    state_next = S_OUT;
                end
                else if (phase_reg == PH_FIRST)
                begin
                    state_next = S_OUT;
                end
                else if (phase_reg == PH_SUB)
                begin
                    if (bb_code == CW'(SUB_PCLEAR))
                    begin
                        state_next = S_P1RD;
                    end
                end
                else if (bb_code != CW'(CODE_CLEAR))
                begin
                    state_next = S_WRD;
                end
            end
            S_WRD:
            begin
                state_next = c_over ? S_OUT : S_WEV;
            end
            S_WEV:
            begin
                if (stk_full || (!walk_free && c_inner && self_ref))
                begin
                    state_next = S_OUT;
                end
                else if (walk_free || c_inner)
                begin
                    state_next = S_WRD;
                end
                else
                begin
                    state_next = nf_full ? S_PRD : S_FRD;
                end
            end
            S_FRD:
            begin
                if (nf_full)
                begin
                    state_next = fromclr_reg ? S_CODE : S_PRD;
                end
                else
                begin
                    state_next = S_FEV;
                end
            end
            S_FEV:
            begin
                if (d_rprefix == FREE_MARK)
                begin
                    state_next = fromclr_reg ? S_CODE : S_PRD;
                end
                else
                begin
                    state_next = S_FRD;
                end
            end
            S_P1RD: state_next = idx_end ? S_P2RD : S_P1WR;
            S_P1WR: state_next = S_P1RD;
            S_P2RD: state_next = idx_end ? S_P3RD : S_P2EV;
            S_P2EV: state_next = p2_hit ? S_P2WR : S_P2RD;
            S_P2WR: state_next = S_P2RD;
            S_P3RD: state_next = idx_end ? S_FRD : S_P3WR;
            S_P3WR: state_next = S_P3RD;
            S_PRD:  state_next = S_POP;
            S_POP:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, unit controls and register next values.
    always_comb
    begin
        phase_next    = phase_reg;
        sp_next       = sp_reg;
        nf_next       = nf_reg;
        idx_next      = idx_reg;
        cw_next       = cw_reg;
        prev_next     = prev_reg;
        code_next     = code_reg;
        c_next        = c_reg;
        final_next    = final_reg;
        first_next    = first_reg;
        fromclr_next  = fromclr_reg;
        end_next      = end_reg;
        corrupt_next  = corrupt_reg;
        done_next     = done_reg;
        bytes_next    = bytes_reg;
        res_byte_next = res_byte_reg;
        res_stat_next = res_stat_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        bb_ctl        = '0;
        d_ctl         = '0;
        d_waddr       = nf_reg[AW-1:0];
        d_wprefix     = 16'(prev_reg);
        d_wsuffix     = d_rsuffix;
        d_raddr       = c_reg[AW-1:0];
        stk_we        = 1'b0;
        stk_waddr     = AW'(sp_reg - SP_W'(1));
        stk_wdata     = final_reg;
        stk_raddr     = sp_reg[AW-1:0];

        case (state_reg)
            S_INIT:
            begin
                d_ctl.pwe = 1'b1;
                d_ctl.swe = 1'b1;
                d_waddr   = idx_reg[AW-1:0];
                if (idx_reg < SP_W'(CODE_CLEAR))
                begin
                    d_wprefix = '0;
                    d_wsuffix = idx_reg[7:0];
                end
                else
                begin
                    d_wprefix = FREE_MARK;
                    d_wsuffix = '0;
                end
                idx_next = idx_reg + SP_W'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    res_byte_next = '0;
                    if (!is_pull)
                    begin
                        if (end_reg)
                        begin
                            res_stat_next = STAT_ACCEPTED;
                        end
                        else if (bb_held > HELD_W'(FULL_HELD))
                        begin
                            res_stat_next = STAT_REFUSED;
                        end
                        else
                        begin
                            bb_ctl.push   = 1'b1;
                            end_next      = s_tlast;
                            res_stat_next = STAT_ACCEPTED;
                        end
                    end
                    else if (corrupt_reg)
                    begin
                        res_stat_next = STAT_CORRUPT;
                    end
                    else if (done_reg)
                    begin
                        res_stat_next = STAT_DONE;
                    end
                    else if (bytes_reg >= limit_reg)
                    begin
                        done_next     = 1'b1;
                        res_stat_next = STAT_DONE;
                    end
                end
            end
            S_CODE:
            begin
                if (short_bits)
                begin
                    if (end_reg)
                    begin
                        done_next     = 1'b1;
                        res_stat_next = STAT_DONE;
                    end
                    else
                    begin
                        res_stat_next = STAT_NEED;
                    end
                end
                else
                begin
                    bb_ctl.take = 1'b1;
                    if (phase_reg == PH_FIRST)
                    begin
                        // The first code is sent out as is.
                        final_next    = bb_code[7:0];
                        prev_next     = bb_code;
                        phase_next    = PH_NORMAL;
                        res_byte_next = bb_code[7:0];
                        res_stat_next = STAT_BYTE;
                        bytes_next    = bytes_reg + 32'd1;
                    end
                    else if (phase_reg == PH_SUB)
                    begin
                        phase_next = PH_NORMAL;
                        if (bb_code == CW'(SUB_WIDEN) && cw_reg < CWID_W'(MAX_CODE_BITS))
                        begin
                            cw_next = cw_reg + CWID_W'(1);
                        end
                        idx_next = FREE_1ST;
                    end
                    else if (bb_code == CW'(CODE_CLEAR))
                    begin
                        phase_next = PH_SUB;
                    end
                    else
                    begin
                        code_next  = bb_code;
                        c_next     = 16'(bb_code);
                        first_next = 1'b1;
                    end
                end
            end
            S_WRD:
            begin
                if (c_over)
                begin
                    corrupt_next  = 1'b1;
                    res_stat_next = STAT_CORRUPT;
                end
            end
            S_WEV:
            begin
                first_next = 1'b0;
                if (walk_free || c_inner || !stk_full)
                begin
                    if (walk_free)
                    begin
                        stk_wdata = final_reg;
                        c_next    = 16'(prev_reg);
                    end
                    else
                    begin
                        stk_wdata = d_rsuffix;
                        c_next    = d_rprefix;
                    end
                end
                if (stk_full || (!walk_free && c_inner && self_ref))
                begin
                    corrupt_next  = 1'b1;
                    res_stat_next = STAT_CORRUPT;
                end
                else
                begin
                    stk_we  = 1'b1;
                    sp_next = sp_reg - SP_W'(1);
                    if (!walk_free && !c_inner)
                    begin
                        // End of the chain: new entry is previous code plus this first byte.
                        final_next   = d_rsuffix;
                        prev_next    = code_reg;
                        fromclr_next = 1'b0;
                        if (!nf_full)
                        begin
                            d_ctl.pwe = 1'b1;
                            d_ctl.swe = 1'b1;
                            nf_next   = nf_reg + SP_W'(1);
                        end
                    end
                end
            end
            S_FRD:
            begin
                d_raddr = nf_reg[AW-1:0];
            end
            S_FEV:
            begin
                if (d_rprefix != FREE_MARK)
                begin
                    nf_next = nf_reg + SP_W'(1);
                end
            end
            S_P1RD:
            begin
                d_raddr = idx_reg[AW-1:0];
                if (idx_end)
                begin
                    idx_next = FREE_1ST;
                end
            end
            S_P1WR:
            begin
                d_ctl.pwe = 1'b1;
                d_waddr   = idx_reg[AW-1:0];
                d_wprefix = d_rprefix | MARK_BIT;
                idx_next  = idx_reg + SP_W'(1);
            end
            S_P2RD:
            begin
                d_raddr = idx_reg[AW-1:0];
                if (idx_end)
                begin
                    idx_next = FREE_1ST;
                end
            end
            S_P2EV:
            begin
                d_raddr = p2_target[AW-1:0];
                if (p2_hit)
                begin
                    c_next = p2_target;
                end
                else
                begin
                    idx_next = idx_reg + SP_W'(1);
                end
            end
            S_P2WR:
            begin
                d_ctl.pwe = 1'b1;
                d_waddr   = c_reg[AW-1:0];
                d_wprefix = d_rprefix & KEEP_MASK;
                idx_next  = idx_reg + SP_W'(1);
            end
            S_P3RD:
            begin
                d_raddr = idx_reg[AW-1:0];
                if (idx_end)
                begin
                    nf_next      = FREE_1ST;
                    fromclr_next = 1'b1;
                end
            end
            S_P3WR:
            begin
                d_ctl.pwe = d_rprefix[15];
                d_waddr   = idx_reg[AW-1:0];
                d_wprefix = FREE_MARK;
                idx_next  = idx_reg + SP_W'(1);
            end
            S_PRD:
            begin
                stk_raddr = sp_reg[AW-1:0];
            end
            S_POP:
            begin
                res_byte_next = stk_q;
                res_stat_next = STAT_BYTE;
                sp_next       = sp_reg + SP_W'(1);
                bytes_next    = bytes_reg + 32'd1;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_byte_reg;
                    m_user_next  = res_stat_reg;
                end
            end
            default:
            begin
                m_valid_next = m_valid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            phase_reg   <= PH_FIRST;
            sp_reg      <= DICT_N;
            nf_reg      <= FREE_1ST;
            idx_reg     <= '0;
            cw_reg      <= CWID_W'(START_CODE_BITS);
            prev_reg    <= '0;
            final_reg   <= '0;
            first_reg   <= 1'b0;
            fromclr_reg <= 1'b0;
            end_reg     <= 1'b0;
            corrupt_reg <= 1'b0;
            done_reg    <= 1'b0;
            bytes_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            sp_reg      <= sp_next;
            nf_reg      <= nf_next;
            idx_reg     <= idx_next;
            cw_reg      <= cw_next;
            prev_reg    <= prev_next;
            final_reg   <= final_next;
            first_reg   <= first_next;
            fromclr_reg <= fromclr_next;
            end_reg     <= end_next;
            corrupt_reg <= corrupt_next;
            done_reg    <= done_next;
            bytes_reg   <= bytes_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 32'hFFFF_FFFF;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        c_reg        <= c_next;
        res_byte_reg <= res_byte_next;
        res_stat_reg <= res_stat_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    `ULZW_ASSERT(a_sp_range, sp_reg <= DICT_N, "stack pointer beyond empty")
    `ULZW_ASSERT(a_cw_range, cw_reg >= CWID_W'(START_CODE_BITS) && cw_reg <= CWID_W'(MAX_CODE_BITS), "code width out of range")
    `ULZW_ASSERT_NEXT(a_corrupt_sticky, corrupt_reg, corrupt_reg, "corrupt flag dropped")
    `ULZW_ASSERT(a_nf_floor, nf_reg >= FREE_1ST && nf_reg <= DICT_N, "next free out of range")
    `ULZW_ASSERT_NEXT(a_out_load, state_reg == S_OUT && out_free, m_tvalid, "result not presented")

endmodule

// ===== sv/ulzw_bitbuf.sv =====
// LSB-first bit buffer: appends compressed bytes and takes codes of 9 to 13 bits.
// Depends on ulzw_pkg.
module ulzw_bitbuf #(
    parameter int CW = 13
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ulzw_pkg::bb_ctl_t                 ctl,
    input  logic [7:0]                        push_byte,
    input  logic [ulzw_pkg::CWID_W-1:0]       width,
    output logic [CW-1:0]                     code,
    output logic [ulzw_pkg::HELD_W-1:0]       held
);
    import ulzw_pkg::*;

    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [BUF_W-1:0]  low_bits;

    // Append and take each use their own shifter; the mask below selects the next code.
    assign low_bits = buf_reg & ~({BUF_W{1'b1}} << width);
    assign code     = low_bits[CW-1:0];
    assign held     = held_reg;

    always_comb
    begin
        buf_next  = buf_reg;
        held_next = held_reg;
        if (ctl.push)
        begin
            buf_next  = buf_reg | (BUF_W'(push_byte) << held_reg);
            held_next = held_reg + HELD_W'(8);
        end
        else if (ctl.take)
        begin
            buf_next  = buf_reg >> width;
            held_next = held_reg - HELD_W'(width);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg  <= '0;
            held_reg <= '0;
        end
        else
        begin
            buf_reg  <= buf_next;
            held_reg <= held_next;
        end
    end

endmodule

// ===== sv/ulzw_dict.sv =====
// Dictionary memories (prefix and suffix) with one write and one registered read port.
// Depends on ulzw_pkg.
module ulzw_dict #(
    parameter int DICT_ENTRIES = 8192,
    parameter int AW = 13
) (
    input  logic                 clk,
    input  ulzw_pkg::dict_ctl_t  ctl,
    input  logic [AW-1:0]        waddr,
    input  logic [15:0]          wprefix,
    input  logic [7:0]           wsuffix,
    input  logic [AW-1:0]        raddr,
    output logic [15:0]          rprefix,
    output logic [7:0]           rsuffix
);
    import ulzw_pkg::*;

    logic [15:0] prefix_mem [DICT_ENTRIES];
    logic [7:0]  suffix_mem [DICT_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (ctl.pwe)
        begin
            prefix_mem[waddr] <= wprefix;
        end
        if (ctl.swe)
        begin
            suffix_mem[waddr] <= wsuffix;
        end
        rprefix <= prefix_mem[raddr];
        rsuffix <= suffix_mem[raddr];
    end

endmodule
